/* hw/rtl/ssg_pkg.sv */
// ssg_pkg: shared constants, codes, types and helpers of the sine sample generator
// no dependencies; used by every module of the block by scoped name

package ssg_pkg;

   localparam int PHASE_BITS     = 32;
   localparam int OUT_BITS       = 16;
   localparam int SINE_ADDR_BITS = 10;

   localparam int WORD_BITS      = 32;
   localparam int FREQ_BITS      = 31;
   localparam int AMP_BITS       = 15;
   localparam int OPCODE_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam int FRAC_BITS  = 30;
   localparam int COEF_BITS  = FRAC_BITS + 1;
   localparam int QUART_BITS = SINE_ADDR_BITS - 2;
   localparam int K_BITS     = SINE_ADDR_BITS - 1;
   localparam int X_SHIFT    = FRAC_BITS - QUART_BITS;
   localparam int X2_SHIFT   = 2 * X_SHIFT - FRAC_BITS;

   localparam int ALIGN_UP = (PHASE_BITS >= WORD_BITS) ? PHASE_BITS - WORD_BITS : 0;
   localparam int ALIGN_DN = (PHASE_BITS < WORD_BITS) ? WORD_BITS - PHASE_BITS : 0;

   localparam int MAG_MUL_BITS = (OUT_BITS - 1 > AMP_BITS) ? OUT_BITS - 1 : AMP_BITS;

   localparam int HORNER_CELLS = 4;

   localparam logic [OPCODE_BITS-1:0] OP_SCALED_START  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_SCALED_CUSTOM = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_UNSCALED      = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FREQ_WORD   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AMPLITUDE   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_PHASE = 2'd2;

   localparam logic [FREQ_BITS-1:0] FREQ_WORD_RESET   = 31'd1;
   localparam logic [AMP_BITS-1:0]  AMPLITUDE_RESET   = 15'd32767;
   localparam logic [WORD_BITS-1:0] START_PHASE_RESET = 32'd0;

   localparam logic [COEF_BITS-1:0] COEF_C9 = 31'd172272;
   localparam logic [COEF_BITS-1:0] HORNER_COEF [HORNER_CELLS] =
      '{31'd5026995, 31'd85569305, 31'd693598669, 31'd1686629713};

   localparam logic [COEF_BITS-1:0] Q30_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [COEF_BITS-1:0] Q30_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

   localparam logic [OUT_BITS-2:0] MAX_MAG = '1;

   typedef logic [MAG_MUL_BITS-1:0] mul_type;
   typedef logic [MAG_MUL_BITS:0]   mag_type;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [1:0]             quad;
      logic [K_BITS-1:0]      k;
   } side_type;

   typedef struct packed {
      side_type             side;
      logic [COEF_BITS-1:0] x2;
      logic [COEF_BITS-1:0] t;
   } cell_type;

   function automatic logic [PHASE_BITS-1:0] align_word(input logic [WORD_BITS-1:0] w);
      logic [PHASE_BITS+WORD_BITS-1:0] wide;
      wide = {{PHASE_BITS{1'b0}}, w};
      wide = (wide << ALIGN_UP) >> ALIGN_DN;
      return wide[PHASE_BITS-1:0];
   endfunction

endpackage

/* hw/rtl/ssg_phase.sv */
// ssg_phase: phase accumulation and quarter-wave folding, two register stages
// depends on ssg_pkg; feeds the first polynomial cell

module ssg_phase (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [ssg_pkg::OPCODE_BITS-1:0]      opcode,
   input  logic signed [ssg_pkg::WORD_BITS-1:0] sample_index,
   input  logic [ssg_pkg::WORD_BITS-1:0]        custom_phase,
   input  logic [ssg_pkg::FREQ_BITS-1:0]        freq_word,
   input  logic [ssg_pkg::WORD_BITS-1:0]        start_phase,
   output logic                                 out_valid,
   output ssg_pkg::cell_type                    out_data
);

   localparam int PB = ssg_pkg::PHASE_BITS;
   localparam int WB = ssg_pkg::WORD_BITS;
   localparam int AB = ssg_pkg::SINE_ADDR_BITS;
   localparam int QB = ssg_pkg::QUART_BITS;
   localparam int KB = ssg_pkg::K_BITS;

   logic [PB+WB-1:0] n_wide;
   logic [PB-1:0]    n_ext;
   logic [PB-1:0]    step;
   logic [2*PB-1:0]  full_prod;
   logic [PB-1:0]    prod_in;
   logic [PB-1:0]    pw_in;

   logic                            valid_a_ff;
   logic [PB-1:0]                   prod_ff;
   logic [PB-1:0]                   pw_ff;
   logic [ssg_pkg::OPCODE_BITS-1:0] opcode_ff;

   logic [PB-1:0]                           phase;
   logic [AB-1:0]                           addr;
   logic [1:0]                              quad;
   logic [KB-1:0]                           k_raw;
   logic [KB-1:0]                           k;
   logic [2*KB-1:0]                         k_sq;
   logic [2*KB+ssg_pkg::X2_SHIFT-1:0]       x2_wide;
   ssg_pkg::cell_type                       data_in;

   logic              valid_b_ff;
   ssg_pkg::cell_type data_ff;

   // sign-extended index times step, kept modulo one turn
   assign n_wide    = {{PB{sample_index[WB-1]}}, sample_index};
   assign n_ext     = n_wide[PB-1:0];
   assign step      = ssg_pkg::align_word({1'b0, freq_word});
   assign full_prod = n_ext * step;
   assign prod_in   = full_prod[PB-1:0];
   assign pw_in     = ssg_pkg::align_word((opcode == ssg_pkg::OP_SCALED_START) ?
                                          start_phase : custom_phase);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         pw_ff     <= pw_in;
         opcode_ff <= opcode;
      end
   end

   // fold into the first quadrant
   assign phase   = prod_ff + pw_ff;
   assign addr    = phase[PB-1 -: AB];
   assign quad    = addr[AB-1 -: 2];
   assign k_raw   = {1'b0, addr[QB-1:0]};
   assign k       = quad[0] ? ({1'b1, {QB{1'b0}}} - k_raw) : k_raw;
   assign k_sq    = k * k;
   assign x2_wide = {k_sq, {ssg_pkg::X2_SHIFT{1'b0}}};

   always_comb begin
      data_in             = '0;
      data_in.side.opcode = opcode_ff;
      data_in.side.quad   = quad;
      data_in.side.k      = k;
      data_in.x2          = x2_wide[ssg_pkg::COEF_BITS-1:0];
      data_in.t           = ssg_pkg::COEF_C9;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/ssg_cell.sv */
// ssg_cell: one step of the odd polynomial, t <= coef - x2 * t in Q30
// depends on ssg_pkg; chained by the top level, one cell per coefficient

module ssg_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  ssg_pkg::cell_type               in_data,
   input  logic [ssg_pkg::COEF_BITS-1:0]   coef,
   output logic                            out_valid,
   output ssg_pkg::cell_type               out_data
);

   localparam int CB = ssg_pkg::COEF_BITS;

   logic [2*CB-1:0]   prod;
   ssg_pkg::cell_type data_in;
   logic              valid_ff;
   ssg_pkg::cell_type data_ff;

   assign prod = in_data.x2 * in_data.t;

   always_comb begin
      data_in   = in_data;
      data_in.t = coef - prod[ssg_pkg::FRAC_BITS +: CB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* hw/rtl/ssg_scale.sv */
// ssg_scale: final polynomial product, clamp, amplitude scaling and sign
// depends on ssg_pkg; holds the result register of the output channel

module ssg_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  ssg_pkg::cell_type                   in_data,
   input  logic [ssg_pkg::AMP_BITS-1:0]        amplitude,
   output logic                                out_valid,
   output logic signed [ssg_pkg::OUT_BITS-1:0] out_sample
);

   localparam int CB = ssg_pkg::COEF_BITS;
   localparam int FB = ssg_pkg::FRAC_BITS;
   localparam int MW = ssg_pkg::MAG_MUL_BITS;
   localparam int OB = ssg_pkg::OUT_BITS;

   logic [CB-1:0]     x;
   logic [2*CB-1:0]   s_prod;
   logic [CB:0]       s_raw;
   logic [CB-1:0]     s_in;

   logic              valid1_ff;
   logic [CB-1:0]     s_ff;
   ssg_pkg::side_type side1_ff;

   logic              scaled;
   logic              unscaled;
   ssg_pkg::mul_type  mul;
   logic [CB-1:0]     rnd;
   logic [CB+MW-1:0]  m_prod;

   logic              valid2_ff;
   ssg_pkg::mag_type  mag_ff;
   logic              neg_ff;
   logic              zero_ff;

   logic [OB-2:0]     mag_sat;
   logic [OB-1:0]     mag_ext;
   logic [OB-1:0]     sample_in;

   logic              valid3_ff;
   logic [OB-1:0]     sample_ff;

   // quarter-wave value, clamped to one
   assign x      = {in_data.side.k, {ssg_pkg::X_SHIFT{1'b0}}};
   assign s_prod = x * in_data.t;
   assign s_raw  = s_prod[2*CB-1:FB];
   assign s_in   = (s_raw > {1'b0, ssg_pkg::Q30_ONE}) ? ssg_pkg::Q30_ONE : s_raw[CB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff     <= s_in;
         side1_ff <= in_data.side;
      end
   end

   // amplitude scaling truncates, the unscaled form rounds half up
   assign scaled   = (side1_ff.opcode == ssg_pkg::OP_SCALED_START) ||
                     (side1_ff.opcode == ssg_pkg::OP_SCALED_CUSTOM);
   assign unscaled = (side1_ff.opcode == ssg_pkg::OP_UNSCALED);
   assign mul      = unscaled ? ssg_pkg::mul_type'(ssg_pkg::MAX_MAG) :
                                ssg_pkg::mul_type'(amplitude);
   assign rnd      = unscaled ? ssg_pkg::Q30_HALF : '0;
   assign m_prod   = s_ff * mul + rnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= m_prod[CB+MW-1:FB];
         neg_ff  <= side1_ff.quad[1];
         zero_ff <= !(scaled || unscaled);
      end
   end

   assign mag_sat = (mag_ff > ssg_pkg::mag_type'(ssg_pkg::MAX_MAG)) ?
                    ssg_pkg::MAX_MAG : mag_ff[OB-2:0];
   assign mag_ext = {1'b0, mag_sat};

   always_comb begin
      if (zero_ff) begin
         sample_in = '0;
      end else if (neg_ff) begin
         sample_in = -mag_ext;
      end else begin
         sample_in = mag_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (en) begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sample_ff <= sample_in;
      end
   end

   assign out_valid  = valid3_ff;
   assign out_sample = sample_ff;

endmodule

/* hw/rtl/sine_sample_generator.sv */
// sine_sample_generator: top level, configuration registers and pipeline control
// depends on ssg_pkg, ssg_phase, ssg_cell and ssg_scale

// Direct digital synthesis of one sine sample per transfer. A request carries an
// opcode, a sample index and a phase word; the response is the sine of
// index * freq_word + phase, scaled by the amplitude and truncated toward zero
// (opcodes 0 and 1) or as an unscaled Q1.15 fraction (opcode 2); opcode 3 gives 0.
// The block is a nine-stage pipeline: two phase stages, a row of four polynomial
// cells and three scaling stages; one request is taken every cycle unless the
// output stalls. The whole pipeline holds while a finished response is stalled
// at the output register. Configuration writes take effect at once and are to
// be made while no transfer is in flight.

module sine_sample_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ssg_pkg::OPCODE_BITS-1:0]        req_opcode,
   input  logic signed [ssg_pkg::WORD_BITS-1:0]   req_sample_index,
   input  logic [ssg_pkg::WORD_BITS-1:0]          req_custom_phase,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ssg_pkg::OUT_BITS-1:0]    rsp_sample,
   input  logic                                   csr_write,
   input  logic [ssg_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ssg_pkg::WORD_BITS-1:0]          csr_data
);

   localparam int NC = ssg_pkg::HORNER_CELLS;

   logic [ssg_pkg::FREQ_BITS-1:0] freq_word_ff;
   logic [ssg_pkg::AMP_BITS-1:0]  amplitude_ff;
   logic [ssg_pkg::WORD_BITS-1:0] start_phase_ff;

   logic              en;
   logic              chain_valid [NC+1];
   ssg_pkg::cell_type chain_data  [NC+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_word_ff   <= ssg_pkg::FREQ_WORD_RESET;
         amplitude_ff   <= ssg_pkg::AMPLITUDE_RESET;
         start_phase_ff <= ssg_pkg::START_PHASE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ssg_pkg::REG_FREQ_WORD: begin
               freq_word_ff <= csr_data[ssg_pkg::FREQ_BITS-1:0];
            end
            ssg_pkg::REG_AMPLITUDE: begin
               amplitude_ff <= csr_data[ssg_pkg::AMP_BITS-1:0];
            end
            ssg_pkg::REG_START_PHASE: begin
               start_phase_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline moves unless a response is held at the output
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   ssg_phase u_phase (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .opcode       (req_opcode),
      .sample_index (req_sample_index),
      .custom_phase (req_custom_phase),
      .freq_word    (freq_word_ff),
      .start_phase  (start_phase_ff),
      .out_valid    (chain_valid[0]),
      .out_data     (chain_data[0])
   );

   for (genvar i = 0; i < NC; i++) begin : g_cell
      ssg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .coef      (ssg_pkg::HORNER_COEF[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   ssg_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (chain_valid[NC]),
      .in_data    (chain_data[NC]),
      .amplitude  (amplitude_ff),
      .out_valid  (rsp_valid),
      .out_sample (rsp_sample)
   );

endmodule
